// ===== design/prle_pkg.sv =====
// Package with the shared constants of the plane run-length encoder.
package prle_pkg;

    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned NUM_SLOTS_W = 3;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned ADDR_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_PLANE_LENGTH = 3'd0;

    localparam logic [31:0] PLANE_LENGTH_RESET = 32'd1;
    localparam logic [31:0] RAW_TAIL_BYTES = 32'd4;
    localparam logic [31:0] SHORT_RUN_LIMIT = 32'd256;
    localparam logic [7:0] ESCAPE_BYTE = 8'hFF;

    localparam logic [2:0] EMIT_NONE = 3'd0;
    localparam logic [2:0] EMIT_SINGLE = 3'd1;
    localparam logic [2:0] EMIT_SHORT = 3'd3;
    localparam logic [2:0] EMIT_LONG = 3'd7;

endpackage

// ===== design/plane_run_length_encoder.sv =====
// Top level of the plane run-length encoder: coding logic and result buffer.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_data_byte
//   output    out        o_out_valid / i_out_ready  o_out_byte .. o_encoded_size
//   config    in         psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// An item is coded in the cycle it is accepted and its results appear in the cycle after.
// An item holds the result buffer until all of its results, up to eight, are taken.
// Items with at most one result stream at one item per cycle while i_out_ready is high.
// A new item is accepted while the last buffered result is being taken.
// Reset is synchronous and active low and loads plane_length with one.
module plane_run_length_encoder
    import prle_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_data_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_last_of_item,
    output logic                o_plane_done,
    output logic                o_raw_fallback,
    output logic [31:0]         o_encoded_size,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [31:0] r_len;
    logic [31:0] r_lim;
    logic        r_len_gt4;

    logic [7:0]  r_held;
    logic [31:0] r_run;
    logic [31:0] r_pos;
    logic [31:0] r_emitted;
    logic        r_gave_up;

    logic [7:0]         r_slot [MAX_RESULTS];
    logic [COUNT_W-1:0] r_nb;
    logic [COUNT_W-1:0] r_total;
    logic [COUNT_W-1:0] r_idx;
    logic               r_fb;
    logic [31:0]        r_size;

    logic               cfg_write;
    logic               take;
    logic               take_last;
    logic               accept;
    logic               is_byte;

    logic               code;
    logic               give1;
    logic               extend;
    logic               gave1;
    logic               give2;
    logic               gave2;
    logic               tail;
    logic               plane_end;
    logic               fb;
    logic [2:0]         k1;
    logic [COUNT_W-1:0] k_all;
    logic [32:0]        sum1;
    logic [32:0]        sum2;
    logic [31:0]        e2;
    logic [32:0]        pos_inc;
    logic [7:0]         cb [MAX_RESULTS];
    logic [7:0]         n_slot [MAX_RESULTS];
    logic [31:0]        n_run;
    logic [31:0]        run_m2;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_PLANE_LENGTH);
    assign prdata = (paddr == ADDR_PLANE_LENGTH) ? r_len : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= PLANE_LENGTH_RESET;
            r_lim <= PLANE_LENGTH_RESET - RAW_TAIL_BYTES;
            r_len_gt4 <= 1'b0;
        end else if (cfg_write) begin
            r_len <= pwdata;
            r_lim <= pwdata - RAW_TAIL_BYTES;
            r_len_gt4 <= pwdata > RAW_TAIL_BYTES;
        end
    end

    assign o_out_valid = r_idx < r_total;
    assign take = o_out_valid && i_out_ready;
    assign take_last = take && ((r_idx + 4'd1) == r_total);
    assign o_in_ready = !o_out_valid || take_last;
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        code = r_len_gt4 && (r_pos != 32'd0) && (r_pos <= r_lim) && !r_gave_up;
        give1 = code && (r_emitted >= r_lim);
        extend = code && !give1 && (r_pos < r_lim) && (r_held == i_data_byte);
        k1 = EMIT_NONE;
        n_run = r_run;
        if (code && !give1 && !extend) begin
            priority if (r_run == 32'd1) begin
                k1 = EMIT_SINGLE;
            end else if (r_run < SHORT_RUN_LIMIT) begin
                k1 = EMIT_SHORT;
                n_run = 32'd1;
            end else begin
                k1 = EMIT_LONG;
                n_run = 32'd1;
            end
        end else if (extend) begin
            n_run = r_run + 32'd1;
        end
        gave1 = r_gave_up || give1;
        sum1 = {1'b0, r_emitted} + {30'd0, k1};
        give2 = r_len_gt4 && (r_pos == r_lim) && !gave1 && (sum1 >= {1'b0, r_lim});
        gave2 = gave1 || give2;
        tail = r_len_gt4 && (r_pos >= r_lim) && (r_pos < r_len) && !gave2;
        k_all = {1'b0, k1} + {3'd0, tail};
        sum2 = {1'b0, r_emitted} + {29'd0, k_all};
        e2 = sum2[32] ? 32'hFFFF_FFFF : sum2[31:0];
        pos_inc = {1'b0, r_pos} + 33'd1;
        plane_end = pos_inc >= {1'b0, r_len};
        fb = !r_len_gt4 || gave2 || (sum2 >= {1'b0, r_len});
        run_m2 = r_run - 32'd2;
        cb[0] = r_held;
        cb[1] = r_held;
        cb[2] = (k1 == EMIT_SHORT) ? run_m2[7:0] : ESCAPE_BYTE;
        cb[3] = r_run[7:0];
        cb[4] = r_run[15:8];
        cb[5] = r_run[23:16];
        cb[6] = r_run[31:24];
        cb[7] = i_data_byte;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            n_slot[i] = (i < int'(k1)) ? cb[i] : i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 8'd0;
            r_run <= 32'd1;
            r_pos <= 32'd0;
            r_emitted <= 32'd0;
            r_gave_up <= 1'b0;
            r_total <= '0;
            r_idx <= '0;
        end else if (accept) begin
            r_total <= k_all + {3'd0, plane_end};
            r_idx <= '0;
            if (plane_end) begin
                r_held <= 8'd0;
                r_run <= 32'd1;
                r_pos <= 32'd0;
                r_emitted <= 32'd0;
                r_gave_up <= 1'b0;
            end else begin
                r_held <= i_data_byte;
                r_run <= n_run;
                r_pos <= pos_inc[31:0];
                r_emitted <= e2;
                r_gave_up <= gave2;
            end
        end else if (take) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot <= n_slot;
            r_nb <= k_all;
            r_fb <= fb;
            r_size <= fb ? r_len : e2;
        end
    end

    assign is_byte = r_idx < r_nb;
    assign o_out_byte = is_byte ? r_slot[r_idx[NUM_SLOTS_W-1:0]] : 8'd0;
    assign o_byte_valid = is_byte;
    assign o_last_of_item = (r_idx + 4'd1) == r_total;
    assign o_plane_done = !is_byte;
    assign o_raw_fallback = !is_byte && r_fb;
    assign o_encoded_size = is_byte ? 32'd0 : r_size;

    a_buffer_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total <= COUNT_W'(MAX_RESULTS)) && (r_idx <= r_total))
        else $error("Result buffer index or count out of range.");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_plane_done) |-> o_last_of_item)
        else $error("Plane status is not the last result of its item.");

    a_plane_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && plane_end) |=> ((r_pos == 32'd0) && (r_run == 32'd1) && !r_gave_up))
        else $error("Plane state not cleared after plane end.");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !take_last) |-> !o_in_ready)
        else $error("Item accepted while earlier results are pending.");

endmodule
